// ===== hdl/sst_pkg.sv =====
package sst_pkg;

   localparam int KW_CHARS_DEFAULT = 8;
   localparam int KW_COUNT_DEFAULT = 12;
   localparam int INDEX_BITS_DEFAULT = 24;

   localparam int KW_SLOTS = 32;
   localparam int KW_MAX_CHARS = 16;
   localparam int IDX_W = 24;
   localparam int POS_W = 16;
   localparam int KIND_W = 5;

   localparam logic [KIND_W-1:0] K_INT = 5'd0;
   localparam logic [KIND_W-1:0] K_FLOAT = 5'd1;
   localparam logic [KIND_W-1:0] K_IDENT = 5'd2;
   localparam logic [KIND_W-1:0] K_KEYWORD = 5'd3;
   localparam logic [KIND_W-1:0] K_STRING = 5'd4;
   localparam logic [KIND_W-1:0] K_SBYTE = 5'd5;
   localparam logic [KIND_W-1:0] K_EL = 5'd6;
   localparam logic [KIND_W-1:0] K_OPBASE = 5'd7;
   localparam logic [KIND_W-1:0] K_GT = 5'd21;
   localparam logic [KIND_W-1:0] K_GTE = 5'd22;
   localparam logic [KIND_W-1:0] K_LT = 5'd23;
   localparam logic [KIND_W-1:0] K_LTE = 5'd24;
   localparam logic [KIND_W-1:0] K_EQ = 5'd25;
   localparam logic [KIND_W-1:0] K_EE = 5'd26;
   localparam logic [KIND_W-1:0] K_END = 5'd27;
   localparam logic [KIND_W-1:0] K_ERROR = 5'd28;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END = 1'b1;

   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_GT = 8'h3E;
   localparam logic [7:0] CH_LT = 8'h3C;

   // Keyword text is right-justified: the first character sits highest.
   localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_SLOTS] = '{
      0: "not", 1: "and", 2: "or", 3: "if", 4: "elif", 5: "else",
      6: "for", 7: "from", 8: "to", 9: "step", 10: "while", 11: "function",
      default: '0
   };
   localparam logic [4:0] KW_LEN [KW_SLOTS] = '{
      0: 5'd3, 1: 5'd3, 2: 5'd2, 3: 5'd2, 4: 5'd4, 5: 5'd4,
      6: 5'd3, 7: 5'd4, 8: 5'd2, 9: 5'd4, 10: 5'd5, 11: 5'd8,
      default: 5'd0
   };

   localparam logic [7:0] OP_CHARS [14] = '{
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h28,
      8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3A, 8'h2C
   };

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  index;
      logic [POS_W-1:0]  line;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  len;
      logic [7:0]        data;
      logic              last;
   } token_type;

   typedef struct packed {
      logic       room;
      logic [1:0] pending;
   } ob_status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic logic [POS_W-1:0] sat16(input logic [POS_W-1:0] v);
      return (&v) ? v : v + 16'd1;
   endfunction

   function automatic logic [7:0] esc_decode(input logic [7:0] c);
      logic [7:0] d;
      if (c == 8'h6E) d = CH_NL;
      else if (c == 8'h74) d = CH_TAB;
      else if (c == CH_BSLASH || c == CH_QUOTE) d = c;
      else d = CH_SPACE;
      return d;
   endfunction

endpackage

// ===== hdl/sst_outbuf.sv =====
module sst_outbuf import sst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  token_type     res0,
   input  token_type     res1,
   input  logic [1:0]    res_count,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output token_type     head,
   output ob_status_type status
);

   logic [1:0] cnt_ff, cnt_in;
   token_type  q0_ff, q0_in, q1_ff, q1_in;
   logic       pop;

   assign pop = (cnt_ff != 2'd0) && !rsp_stall;
   assign rsp_valid = cnt_ff != 2'd0;
   assign head = q0_ff;
   assign status.room = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign status.pending = cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      q0_in = q0_ff;
      q1_in = q1_ff;
      // A push is only issued when the buffer is empty or its last entry drains this cycle.
      if (push) begin
         q0_in = res0;
         q1_in = res1;
         cnt_in = res_count;
      end else if (pop) begin
         q0_in = q1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

endmodule

// ===== hdl/sst_core.sv =====
module sst_core import sst_pkg::*; #(
   parameter int KEYWORD_CHARS = KW_CHARS_DEFAULT,
   parameter int KEYWORD_COUNT = KW_COUNT_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       process,
   input  logic       op,
   input  logic [7:0] char_byte,
   output token_type  res0,
   output token_type  res1,
   output logic [1:0] res_count
);

   localparam int KB = $clog2(KEYWORD_CHARS);

   typedef enum logic [7:0] {
      M_IDLE  = 8'b0000_0001,
      M_NUM   = 8'b0000_0010,
      M_IDENT = 8'b0000_0100,
      M_STR   = 8'b0000_1000,
      M_ESC   = 8'b0001_0000,
      M_GT    = 8'b0010_0000,
      M_LT    = 8'b0100_0000,
      M_EQ    = 8'b1000_0000
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in, ts_idx_ff, ts_idx_in;
   logic [POS_W-1:0]      line_ff, line_in, col_ff, col_in;
   logic [POS_W-1:0]      ts_line_ff, ts_line_in, ts_col_ff, ts_col_in;
   logic [POS_W-1:0]      tlen_ff, tlen_in;
   logic                  dot_ff, dot_in, open_ff, open_in, halt_ff, halt_in;
   logic [7:0]            nb_ff [KEYWORD_CHARS];
   logic [7:0]            nb_in [KEYWORD_CHARS];

   logic                  cons, fl, disp;
   logic [7:0]            c;
   logic [1:0]            n;
   token_type             q [2];

   function automatic token_type mk(input logic [KIND_W-1:0] kind,
                                    input logic [INDEX_BITS-1:0] idx,
                                    input logic [POS_W-1:0] line,
                                    input logic [POS_W-1:0] col,
                                    input logic [POS_W-1:0] len,
                                    input logic [7:0] data);
      token_type t;
      t.kind = kind;
      t.index = ((idx >> IDX_W) != '0) ? '1 : IDX_W'(idx);
      t.line = line;
      t.col = col;
      t.len = len;
      t.data = data;
      t.last = 1'b0;
      return t;
   endfunction

   function automatic logic is_kw(input logic [7:0] nb [KEYWORD_CHARS],
                                  input logic [POS_W-1:0] len);
      logic hit, same;
      int   pos;
      hit = 1'b0;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         same = (len <= POS_W'(KEYWORD_CHARS)) && (len != '0)
                && (len == POS_W'(KW_LEN[i]));
         for (int k = 0; k < KEYWORD_CHARS; k++) begin
            if (k < int'(KW_LEN[i])) begin
               pos = int'(KW_LEN[i]) - 1 - k;
               if (nb[k] != KW_TEXT[i][8*pos +: 8]) same = 1'b0;
            end
         end
         hit = hit | same;
      end
      return hit;
   endfunction

   always_comb begin
      mode_in = mode_ff;
      idx_in = idx_ff;
      line_in = line_ff;
      col_in = col_ff;
      ts_idx_in = ts_idx_ff;
      ts_line_in = ts_line_ff;
      ts_col_in = ts_col_ff;
      tlen_in = tlen_ff;
      dot_in = dot_ff;
      open_in = open_ff;
      halt_in = halt_ff;
      nb_in = nb_ff;
      cons = 1'b0;
      fl = 1'b0;
      disp = 1'b0;
      c = char_byte;
      n = 2'd0;
      q[0] = '0;
      q[1] = '0;

      if (process && (op == OP_END || !halt_ff)) begin
         // The first item of a text restarts index and column on a new line.
         if (!halt_ff && !open_ff) begin
            open_in = 1'b1;
            idx_in = '0;
            col_in = '0;
            line_in = sat16(line_ff);
         end

         if (op == OP_END) begin
            fl = !halt_ff;
         end else begin
            unique case (mode_ff)
               M_NUM: begin
                  if (is_digit(c)) cons = 1'b1;
                  else if (c == CH_DOT && !dot_ff) begin
                     dot_in = 1'b1;
                     cons = 1'b1;
                  end else fl = 1'b1;
               end
               M_IDENT: begin
                  if (is_alpha(c) || is_digit(c)) begin
                     if (tlen_ff < POS_W'(KEYWORD_CHARS)) nb_in[tlen_ff[KB-1:0]] = c;
                     cons = 1'b1;
                  end else fl = 1'b1;
               end
               M_GT, M_LT, M_EQ: begin
                  if (c == CH_EQ) begin
                     cons = 1'b1;
                     q[n[0]] = mk(mode_ff == M_GT ? K_GTE : mode_ff == M_LT ? K_LTE : K_EE,
                                  ts_idx_ff, ts_line_ff, ts_col_ff, sat16(tlen_ff), 8'd0);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                  end else fl = 1'b1;
               end
               M_STR: begin
                  cons = 1'b1;
                  if (c == CH_QUOTE) begin
                     q[n[0]] = mk(K_STRING, ts_idx_ff, ts_line_ff, ts_col_ff,
                                  sat16(tlen_ff), 8'd0);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                  end else if (c == CH_BSLASH) begin
                     mode_in = M_ESC;
                  end else begin
                     q[n[0]] = mk(K_SBYTE, idx_in, line_in, col_in, 16'd1, c);
                     n = n + 2'd1;
                  end
               end
               M_ESC: begin
                  cons = 1'b1;
                  q[n[0]] = mk(K_SBYTE, idx_in, line_in, col_in, 16'd2, esc_decode(c));
                  n = n + 2'd1;
                  mode_in = M_STR;
               end
               M_IDLE: disp = 1'b1;
            endcase
         end

         // Close the token in progress before the current item is looked at.
         if (fl) begin
            unique case (mode_ff)
               M_NUM: begin
                  q[n[0]] = mk(dot_ff ? K_FLOAT : K_INT, ts_idx_ff, ts_line_ff,
                               ts_col_ff, tlen_ff, 8'd0);
                  n = n + 2'd1;
               end
               M_IDENT: begin
                  q[n[0]] = mk(is_kw(nb_ff, tlen_ff) ? K_KEYWORD : K_IDENT, ts_idx_ff,
                               ts_line_ff, ts_col_ff, tlen_ff, 8'd0);
                  n = n + 2'd1;
               end
               M_STR, M_ESC: begin
                  q[n[0]] = mk(K_STRING, ts_idx_ff, ts_line_ff, ts_col_ff, tlen_ff, 8'd0);
                  n = n + 2'd1;
               end
               M_GT, M_LT, M_EQ: begin
                  q[n[0]] = mk(mode_ff == M_GT ? K_GT : mode_ff == M_LT ? K_LT : K_EQ,
                               ts_idx_ff, ts_line_ff, ts_col_ff, tlen_ff, 8'd0);
                  n = n + 2'd1;
               end
               M_IDLE: ;
            endcase
            mode_in = M_IDLE;
            disp = op == OP_BYTE;
         end

         if (op == OP_END) begin
            q[n[0]] = mk(K_END, idx_in, line_in, col_in, 16'd0, 8'd0);
            n = n + 2'd1;
            halt_in = 1'b0;
            open_in = 1'b0;
            mode_in = M_IDLE;
         end else if (disp) begin
            if (c == CH_SPACE || c == CH_TAB) begin
               cons = 1'b1;
            end else if (is_digit(c) || is_alpha(c) || c == CH_GT || c == CH_LT
                         || c == CH_EQ || c == CH_QUOTE) begin
               ts_idx_in = idx_in;
               ts_line_in = line_in;
               ts_col_in = col_in;
               tlen_in = '0;
               dot_in = 1'b0;
               cons = 1'b1;
               if (is_digit(c)) mode_in = M_NUM;
               else if (is_alpha(c)) begin
                  mode_in = M_IDENT;
                  nb_in[0] = c;
               end else if (c == CH_GT) mode_in = M_GT;
               else if (c == CH_LT) mode_in = M_LT;
               else if (c == CH_EQ) mode_in = M_EQ;
               else mode_in = M_STR;
            end else if (c == CH_NL || c == CH_SEMI) begin
               q[n[0]] = mk(K_EL, idx_in, line_in, col_in, 16'd1, c);
               n = n + 2'd1;
               cons = 1'b1;
            end else begin
               q[n[0]] = mk(K_ERROR, idx_in, line_in, col_in, 16'd1, 8'd0);
               for (int i = 0; i < 14; i++) begin
                  if (OP_CHARS[i] == c) q[n[0]].kind = K_OPBASE + KIND_W'(i);
               end
               if (q[n[0]].kind == K_ERROR) halt_in = 1'b1;
               else cons = 1'b1;
               n = n + 2'd1;
            end
         end

         if (cons) begin
            tlen_in = sat16(tlen_in);
            if (!(&idx_in)) idx_in = idx_in + 1'b1;
            col_in = sat16(col_in);
            if (c == CH_NL) begin
               line_in = sat16(line_in);
               col_in = '0;
            end
         end
      end

      if (n == 2'd1) q[0].last = 1'b1;
      q[1].last = 1'b1;
   end

   assign res0 = q[0];
   assign res1 = q[1];
   assign res_count = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         idx_ff <= '0;
         line_ff <= '0;
         col_ff <= '0;
         ts_idx_ff <= '0;
         ts_line_ff <= '0;
         ts_col_ff <= '0;
         tlen_ff <= '0;
         dot_ff <= 1'b0;
         open_ff <= 1'b0;
         halt_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         idx_ff <= idx_in;
         line_ff <= line_in;
         col_ff <= col_in;
         ts_idx_ff <= ts_idx_in;
         ts_line_ff <= ts_line_in;
         ts_col_ff <= ts_col_in;
         tlen_ff <= tlen_in;
         dot_ff <= dot_in;
         open_ff <= open_in;
         halt_ff <= halt_in;
      end
      nb_ff <= nb_in;
   end

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// Streaming tokenizer: each item is one source byte (req_op low) or an end-of-text
// marker (req_op high), and yields zero, one or two tokens on the rsp_ channel,
// rsp_last marking the final token of an item. Items pass through an input register,
// combinational scan logic and a two-entry result buffer, so one item is taken per
// cycle while each item gives at most one token and rsp_stall stays low; an item
// that gives two tokens holds the next one while the buffer drains. An illegal
// byte gives an error token and all bytes up to the end-of-text marker are then
// dropped.
module source_text_tokenizer import sst_pkg::*; #(
   parameter int KEYWORD_CHARS = KW_CHARS_DEFAULT,
   parameter int KEYWORD_COUNT = KW_COUNT_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [7:0]         req_char_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_token_kind,
   output logic [IDX_W-1:0]   rsp_start_index,
   output logic [POS_W-1:0]   rsp_start_line,
   output logic [POS_W-1:0]   rsp_start_col,
   output logic [POS_W-1:0]   rsp_token_len,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_last
);

   logic          in_valid_ff, in_valid_in;
   logic          op_ff, op_in;
   logic [7:0]    char_ff, char_in;
   logic          process;
   token_type     res0, res1, head;
   logic [1:0]    res_count;
   ob_status_type ob_status;

   assign process = in_valid_ff && ob_status.room;
   assign req_stall = in_valid_ff && !process;

   always_comb begin
      in_valid_in = in_valid_ff;
      op_in = op_ff;
      char_in = char_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         op_in = req_op;
         char_in = req_char_byte;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      op_ff <= op_in;
      char_ff <= char_in;
   end

   sst_core #(
      .KEYWORD_CHARS(KEYWORD_CHARS),
      .KEYWORD_COUNT(KEYWORD_COUNT),
      .INDEX_BITS(INDEX_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .process(process),
      .op(op_ff),
      .char_byte(char_ff),
      .res0(res0),
      .res1(res1),
      .res_count(res_count)
   );

   sst_outbuf u_outbuf (
      .clock(clock),
      .reset(reset),
      .push(process),
      .res0(res0),
      .res1(res1),
      .res_count(res_count),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .head(head),
      .status(ob_status)
   );

   assign rsp_token_kind = head.kind;
   assign rsp_start_index = head.index;
   assign rsp_start_line = head.line;
   assign rsp_start_col = head.col;
   assign rsp_token_len = head.len;
   assign rsp_data_byte = head.data;
   assign rsp_last = head.last;

   // A waiting item must not be overwritten before the scan logic takes it.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !process) |=> (in_valid_ff && $stable(op_ff) && $stable(char_ff)))
      else $error("waiting item lost");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (ob_status.pending == 2'd2) |-> !rsp_last)
      else $error("first of two tokens marked last");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == K_END) |-> (rsp_token_len == '0 && rsp_last))
      else $error("malformed end token");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (process && res_count != 2'd0) |=> rsp_valid)
      else $error("tokens dropped");

endmodule
